// ----- hw/rtl/multi_channel_event_timer_unit_macros.svh -----
// Assertion macros for the event timer bank.
// Depends on nothing; included by modules that carry assertions.
`ifndef MULTI_CHANNEL_EVENT_TIMER_UNIT_MACROS_SVH
`define MULTI_CHANNEL_EVENT_TIMER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define MCET_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("event timer check failed");

// next-cycle implication, disabled in reset
`define MCET_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("event timer check failed");

`endif

// ----- hw/rtl/mcet_pkg.sv -----
// Package for the event timer bank: word types, codes and sizes.
// Depends on nothing; imported by multi_channel_event_timer_unit.
`timescale 1ns / 1ps

package mcet_pkg;

    localparam int NUM_TIMERS_DEF  = 4;
    localparam int NUM_PERIOD_REGS = 4;
    localparam int PERIOD_W        = 15;
    localparam int ELAPSED_W       = 16;
    localparam int MASK_W          = 4;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 15;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_ZERO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_ONE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TWO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_THREE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MASK  = 3'd4;

    typedef enum logic [2:0] {
        FUNC_TICK    = 3'd0,
        FUNC_START   = 3'd1,
        FUNC_STOP    = 3'd2,
        FUNC_ENABLE  = 3'd3,
        FUNC_DISABLE = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_START = 2'd1,
        EV_END   = 2'd2
    } event_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CMD,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [2:0]           func;
        logic [1:0]           timer_id;
        logic [ELAPSED_W-1:0] elapsed_ms;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        event_kind;
        logic [1:0]        event_timer;
        logic [MASK_W-1:0] active_mask;
        logic              last;
    } out_item_t;

endpackage

// ----- hw/rtl/multi_channel_event_timer_unit.sv -----
// Event timer bank top level: sequencer, timer state and one shared subtractor.
// Depends on mcet_pkg and multi_channel_event_timer_unit_macros.svh.
//
//  channel | direction | handshake               | word
//  in      | input     | in_valid / in_ready     | in_data  (func, timer_id, elapsed_ms)
//  out     | output    | out_valid / out_ready   | out_data (event_kind, event_timer,
//          |           |                         |           active_mask, last)
//  cfg     | input     | cfg_wr_en               | cfg_index, cfg_data
//
// A tick scans the timers in turn: one subtract and compare per timer on the
// shared unit, then a flush step posts the final word. Other commands go through ST_CMD, then ST_FLUSH.
// Each expiring timer gives one word; a full output register stalls the scan.
// Reset clears timers, config registers, state and flags at once; no clearing pass. Data registers are not reset.
`timescale 1ns / 1ps
`include "multi_channel_event_timer_unit_macros.svh"

module multi_channel_event_timer_unit #(
    parameter int NUM_TIMERS = mcet_pkg::NUM_TIMERS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  mcet_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output mcet_pkg::out_item_t                 out_data,
    input  logic                                cfg_wr_en,
    input  logic [mcet_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mcet_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import mcet_pkg::*;

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [2:0]            func_reg;
    logic [1:0]            id_reg;
    logic [ELAPSED_W-1:0]  elapsed_reg;
    logic [PERIOD_W-1:0]   remaining_reg [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] active_reg, active_next;
    logic [PERIOD_W-1:0]   period_reg [NUM_PERIOD_REGS];
    logic [MASK_W-1:0]     repeat_reg;
    logic                  pend_valid_reg, pend_valid_next;
    out_item_t             pend_reg, pend_next;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_reg, out_next;

    logic [IDX_W-1:0]      cur_idx;
    logic [PERIOD_W-1:0]   cur_rem;
    logic [PERIOD_W-1:0]   cur_period;
    logic                  cur_repeat;
    logic                  cur_active;
    logic                  expire;
    logic [PERIOD_W-1:0]   diff;
    logic                  slot_free;
    logic                  scan_stall;
    logic                  id_ok;
    logic                  idx_last;
    logic                  rem_we;
    logic [PERIOD_W-1:0]   rem_wdata;
    logic                  ev_set;
    event_t                ev_kind;
    logic [MASK_W-1:0]     mask_after;

    assign cur_idx    = (state_reg == ST_CMD) ? IDX_W'(id_reg) : idx_reg;
    assign cur_rem    = remaining_reg[cur_idx];
    assign cur_active = active_reg[cur_idx];
    assign cur_period = (32'(cur_idx) < NUM_PERIOD_REGS) ? period_reg[2'(cur_idx)]
                                                         : '0;
    assign cur_repeat = (32'(cur_idx) < NUM_PERIOD_REGS) && repeat_reg[2'(cur_idx)];
    assign expire     = ({1'b0, cur_rem} <= elapsed_reg);
    assign diff       = cur_rem - elapsed_reg[PERIOD_W-1:0];
    assign slot_free  = !out_valid_reg || out_ready;
    assign scan_stall = cur_active && expire && pend_valid_reg && !slot_free;
    assign id_ok      = (32'(id_reg) < NUM_TIMERS);
    assign idx_last   = (idx_reg == IDX_W'(NUM_TIMERS - 1));

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_data.func == FUNC_TICK) ? ST_SCAN : ST_CMD;
                end
            end
            ST_SCAN:
            begin
                if (!scan_stall && idx_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_CMD:
            begin
                state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // timer update, pending event and output word
    always_comb
    begin
        idx_next        = idx_reg;
        active_next     = active_reg;
        rem_we          = 1'b0;
        rem_wdata       = cur_rem;
        ev_set          = 1'b0;
        ev_kind         = EV_NONE;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                idx_next        = '0;
                pend_valid_next = 1'b0;
            end
            ST_SCAN:
            begin
                if (!scan_stall)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (cur_active)
                    begin
                        rem_we    = 1'b1;
                        rem_wdata = diff;
                        if (expire)
                        begin
                            ev_set = 1'b1;
                            if (cur_repeat)
                            begin
                                rem_wdata = cur_period;
                                ev_kind   = EV_START;
                            end
                            else
                            begin
                                rem_wdata            = '0;
                                active_next[cur_idx] = 1'b0;
                                ev_kind              = EV_END;
                            end
                        end
                    end
                end
            end
            ST_CMD:
            begin
                if (id_ok)
                begin
                    case (func_reg)
                        FUNC_START:
                        begin
                            rem_we               = 1'b1;
                            rem_wdata            = cur_period;
                            active_next[cur_idx] = 1'b1;
                            ev_set               = 1'b1;
                            ev_kind              = EV_START;
                        end
                        FUNC_STOP:
                        begin
                            if (cur_active)
                            begin
                                rem_we               = 1'b1;
                                rem_wdata            = '0;
                                active_next[cur_idx] = 1'b0;
                                ev_set               = 1'b1;
                                ev_kind              = EV_END;
                            end
                        end
                        FUNC_ENABLE:
                        begin
                            active_next[cur_idx] = 1'b1;
                        end
                        FUNC_DISABLE:
                        begin
                            active_next[cur_idx] = 1'b0;
                        end
                        default:
                        begin
                            active_next = active_reg;
                        end
                    endcase
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase

        mask_after = '0;
        for (int t = 0; t < NUM_TIMERS && t < MASK_W; t++)
        begin
            mask_after[t] = active_next[t];
        end

        if (ev_set)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
            end
            pend_valid_next       = 1'b1;
            pend_next.event_kind  = ev_kind;
            pend_next.event_timer = 2'(cur_idx);
            pend_next.active_mask = mask_after;
            pend_next.last        = 1'b0;
        end

        if (state_reg == ST_FLUSH && slot_free)
        begin
            out_valid_next = 1'b1;
            if (pend_valid_reg)
            begin
                out_next      = pend_reg;
                out_next.last = 1'b1;
            end
            else
            begin
                out_next.event_kind  = EV_NONE;
                out_next.event_timer = '0;
                out_next.active_mask = mask_after;
                out_next.last        = 1'b1;
            end
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            active_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            repeat_reg     <= '0;
            for (int p = 0; p < NUM_PERIOD_REGS; p++)
            begin
                period_reg[p] <= '0;
            end
            for (int t = 0; t < NUM_TIMERS; t++)
            begin
                remaining_reg[t] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            active_reg     <= active_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (rem_we)
            begin
                remaining_reg[cur_idx] <= rem_wdata;
            end
            if (cfg_wr_en)
            begin
                if (cfg_index < REG_REPEAT_MASK)
                begin
                    period_reg[cfg_index[1:0]] <= cfg_data[PERIOD_W-1:0];
                end
                else if (cfg_index == REG_REPEAT_MASK)
                begin
                    repeat_reg <= cfg_data[MASK_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
        if (in_valid && in_ready)
        begin
            func_reg    <= in_data.func;
            id_reg      <= in_data.timer_id;
            elapsed_reg <= in_data.elapsed_ms;
        end
    end

    `MCET_ASSERT_NOW(a_pend_mid_item, clk, rst_n, pend_valid_reg, (state_reg == ST_SCAN) || (state_reg == ST_CMD) || (state_reg == ST_FLUSH))
    `MCET_ASSERT_NEXT(a_flush_posts_last, clk, rst_n, (state_reg == ST_FLUSH) && slot_free, out_valid_reg && out_reg.last && (state_reg == ST_IDLE))
    `MCET_ASSERT_NOW(a_none_has_no_timer, clk, rst_n, out_valid_reg && (out_reg.event_kind == EV_NONE), (out_reg.event_timer == 2'd0) && out_reg.last)
    `MCET_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready, (state_reg == ST_SCAN) || (state_reg == ST_CMD))

endmodule

// ----- sim/tb_multi_channel_event_timer_unit.sv -----
// Self-checking testbench for the four-channel event timer bank.
// Depends on mcet_pkg and multi_channel_event_timer_unit; predicts every event word on the fly.
`timescale 1ns / 1ps

module tb_multi_channel_event_timer_unit;
    import mcet_pkg::*;

    localparam int TIMERS        = NUM_TIMERS_DEF;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_LIMIT   = 50000;
    localparam int RANDOM_ITEMS  = 65;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // mirror of the timer bank
    logic [PERIOD_W-1:0]   period_ms [NUM_PERIOD_REGS] = '{default: '0};
    logic [MASK_W-1:0]     repeat_bits = '0;
    logic signed [17:0]    left_ms [TIMERS] = '{default: '0};
    logic [MASK_W-1:0]     running = '0;

    out_item_t             timer_events_due [$];
    int                    fault_count = 0;
    int                    sender_gap_pct = 0;
    int                    receiver_stall_pct = 0;
    int                    holds_asked = 0;

    multi_channel_event_timer_unit #(.NUM_TIMERS(TIMERS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("** multi_channel_event_timer_unit: FAILED **");
        $finish;
    end

    function automatic void push_event(input event_t kind, input int t);
        out_item_t w;
        w.event_kind  = kind;
        w.event_timer = (kind == EV_NONE) ? 2'd0 : t[1:0];
        w.active_mask = running;
        w.last        = 1'b0;
        timer_events_due.push_back(w);
    endfunction

    function automatic void predict_timer_events(input in_item_t w);
        int n;
        logic signed [17:0] left;
        n = 0;
        if (w.func == FUNC_TICK)
        begin
            for (int t = 0; t < TIMERS; t++)
            begin
                if (running[t])
                begin
                    left = left_ms[t] - $signed({2'b00, w.elapsed_ms});
                    if (left > 0)
                        left_ms[t] = left;
                    else if (repeat_bits[t])
                    begin
                        left_ms[t] = $signed({3'b000, period_ms[t]});
                        push_event(EV_START, t);
                        n++;
                    end
                    else
                    begin
                        left_ms[t]  = '0;
                        running[t]  = 1'b0;
                        push_event(EV_END, t);
                        n++;
                    end
                end
            end
        end
        else if (w.timer_id < TIMERS)
        begin
            case (w.func)
                FUNC_START:
                begin
                    left_ms[w.timer_id] = $signed({3'b000, period_ms[w.timer_id]});
                    running[w.timer_id] = 1'b1;
                    push_event(EV_START, w.timer_id);
                    n++;
                end
                FUNC_STOP:
                begin
                    if (running[w.timer_id])
                    begin
                        left_ms[w.timer_id] = '0;
                        running[w.timer_id] = 1'b0;
                        push_event(EV_END, w.timer_id);
                        n++;
                    end
                end
                FUNC_ENABLE:  running[w.timer_id] = 1'b1;
                FUNC_DISABLE: running[w.timer_id] = 1'b0;
                default: ;
            endcase
        end
        if (n == 0)
            push_event(EV_NONE, 0);
        timer_events_due[timer_events_due.size() - 1].last = 1'b1;
    endfunction

    always @(posedge clk)
    begin : watch_words
        out_item_t due;
        if (rst_n && out_valid && out_ready)
        begin
            if (timer_events_due.size() == 0)
            begin
                if (fault_count < 10)
                    $display("unexpected word: kind %0d timer %0d mask %h last %0d",
                             out_data.event_kind, out_data.event_timer,
                             out_data.active_mask, out_data.last);
                fault_count++;
            end
            else
            begin
                due = timer_events_due.pop_front();
                if (out_data.event_kind !== due.event_kind ||
                    out_data.event_timer !== due.event_timer ||
                    out_data.active_mask !== due.active_mask ||
                    out_data.last !== due.last)
                begin
                    if (fault_count < 10)
                    begin
                        $display("word mismatch at %0t: expected kind %0d timer %0d mask %h last %0d",
                                 $realtime, due.event_kind, due.event_timer,
                                 due.active_mask, due.last);
                        $display("    got kind %0d timer %0d mask %h last %0d",
                                 out_data.event_kind, out_data.event_timer,
                                 out_data.active_mask, out_data.last);
                    end
                    fault_count++;
                end
            end
        end
        if (rst_n && in_valid && in_ready)
            predict_timer_events(in_data);
    end

    // hold off for a long stretch on request, otherwise stall at random
    initial
    begin : drive_out_ready
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        forever
        begin
            @(posedge clk);
            if (holds_served != holds_asked)
            begin
                holds_served = holds_asked;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    function automatic in_item_t make_word(input logic [2:0] func, input logic [1:0] id,
                                           input logic [ELAPSED_W-1:0] elapsed);
        in_item_t w;
        w.func       = func;
        w.timer_id   = id;
        w.elapsed_ms = elapsed;
        return w;
    endfunction

    task automatic send_word(input in_item_t w);
        while ($urandom_range(99) < sender_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain_bank();
        in_valid <= 1'b0;
        @(posedge clk);
        while (timer_events_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic load_settings(input logic [PERIOD_W-1:0] p0, p1, p2, p3,
                                 input logic [MASK_W-1:0] rep, input bit poke_spare);
        logic [CFG_DATA_W-1:0] vals [5];
        vals = '{p0, p1, p2, p3, {(CFG_DATA_W - MASK_W)'($urandom), rep}};
        for (int i = REG_PERIOD_ZERO; i <= REG_REPEAT_MASK; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_data  <= vals[i];
            @(posedge clk);
            if (i < NUM_PERIOD_REGS)
                period_ms[i] = vals[i];
            else
                repeat_bits = vals[i][MASK_W-1:0];
        end
        if (poke_spare)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'($urandom_range(REG_REPEAT_MASK + 1, 2 ** CFG_IDX_W - 1));
            cfg_data  <= CFG_DATA_W'($urandom);
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [PERIOD_W-1:0] random_period();
        int r;
        r = $urandom_range(99);
        if (r < 12)
            return '0;
        else if (r < 20)
            return '1;
        else if (r < 30)
            return PERIOD_W'($urandom_range(2 ** PERIOD_W - 1));
        return PERIOD_W'($urandom_range(1, 60));
    endfunction

    function automatic logic [ELAPSED_W-1:0] random_elapsed();
        int r;
        r = $urandom_range(99);
        if (r < 12)
            return '0;
        else if (r < 16)
            return '1;
        else if (r < 22)
            return ELAPSED_W'($urandom_range(2 ** ELAPSED_W - 1));
        return ELAPSED_W'($urandom_range(1, 40));
    endfunction

    function automatic in_item_t random_word();
        in_item_t w;
        int pick;
        pick         = $urandom_range(99);
        w.timer_id   = 2'($urandom_range(TIMERS - 1));
        w.elapsed_ms = ELAPSED_W'($urandom_range(2 ** ELAPSED_W - 1));
        if (pick < 42)
        begin
            w.func       = FUNC_TICK;
            w.elapsed_ms = random_elapsed();
        end
        else if (pick < 66)
            w.func = FUNC_START;
        else if (pick < 78)
            w.func = FUNC_STOP;
        else if (pick < 86)
            w.func = FUNC_ENABLE;
        else if (pick < 94)
            w.func = FUNC_DISABLE;
        else
            w.func = 3'($urandom_range(FUNC_DISABLE + 1, 2 ** $bits(func_t) - 1));
        return w;
    endfunction

    task automatic test_idle_bank();
        send_word(make_word(FUNC_TICK, 2'd0, '0));
        send_word(make_word(FUNC_TICK, 2'd3, '1));
        send_word(make_word(FUNC_STOP, 2'd3, '0));
        send_word(make_word(FUNC_DISABLE, 2'd1, '0));
        for (int f = FUNC_DISABLE + 1; f < 2 ** $bits(func_t); f++)
            send_word(make_word(f[2:0], 2'd3, '1));
    endtask

    task automatic test_one_shot();
        drain_bank();
        load_settings(15'd5, '1, '0, 15'd1, '0, 1'b1);
        for (int t = 0; t < TIMERS; t++)
            send_word(make_word(FUNC_START, t[1:0], '0));
        send_word(make_word(FUNC_TICK, 2'd0, 16'd4));
        send_word(make_word(FUNC_TICK, 2'd0, '1));
        send_word(make_word(FUNC_TICK, 2'd0, '0));
        send_word(make_word(FUNC_STOP, 2'd0, '0));
    endtask

    task automatic test_auto_repeat();
        drain_bank();
        load_settings(15'd3, '1, '0, 15'd10, '1, 1'b0);
        send_word(make_word(FUNC_START, 2'd2, '0));
        send_word(make_word(FUNC_TICK, 2'd0, '0));
        send_word(make_word(FUNC_START, 2'd0, '0));
        send_word(make_word(FUNC_START, 2'd1, '0));
        send_word(make_word(FUNC_START, 2'd3, '0));
        send_word(make_word(FUNC_TICK, 2'd0, '1));
        send_word(make_word(FUNC_STOP, 2'd1, '0));
        send_word(make_word(FUNC_TICK, 2'd0, 16'd2));
    endtask

    task automatic test_enable_disable();
        drain_bank();
        load_settings(15'd7, 15'd7, 15'd7, 15'd7, '0, 1'b0);
        send_word(make_word(FUNC_DISABLE, 2'd0, '0));
        send_word(make_word(FUNC_DISABLE, 2'd2, '0));
        send_word(make_word(FUNC_DISABLE, 2'd3, '0));
        send_word(make_word(FUNC_ENABLE, 2'd1, '0));
        send_word(make_word(FUNC_TICK, 2'd0, '0));
        send_word(make_word(FUNC_ENABLE, 2'd0, '0));
        send_word(make_word(FUNC_TICK, 2'd0, 16'd1));
    endtask

    task automatic run_random_stretch(input int gap_pct, input int stall_pct, input int count);
        in_item_t w;
        int done;
        sender_gap_pct     = gap_pct;
        receiver_stall_pct = stall_pct;
        for (int half = 0; half < 2; half++)
        begin
            drain_bank();
            load_settings(random_period(), random_period(), random_period(), random_period(),
                          MASK_W'($urandom_range(2 ** MASK_W - 1)), 1'($urandom_range(1)));
            done = 0;
            while (done < count / 2)
            begin
                w = random_word();
                send_word(w);
                if (w.func <= FUNC_DISABLE)
                    done++;
            end
        end
    endtask

    task automatic test_output_backpressure();
        drain_bank();
        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
        load_settings(15'd20, 15'd20, 15'd20, 15'd20, 4'b1010, 1'b0);
        for (int t = 0; t < TIMERS; t++)
            send_word(make_word(FUNC_START, t[1:0], '0));
        holds_asked++;
        repeat (20)
            send_word(make_word(FUNC_TICK, 2'd0, ELAPSED_W'($urandom_range(5, 25))));
    endtask

    initial
    begin : run_tests
        int waited;
        int missing;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_bank();
        test_one_shot();
        test_auto_repeat();
        test_enable_disable();
        run_random_stretch(0, 0, RANDOM_ITEMS);
        run_random_stretch(66, 0, RANDOM_ITEMS);
        run_random_stretch(0, 66, RANDOM_ITEMS);
        run_random_stretch(32, 32, RANDOM_ITEMS);
        test_output_backpressure();
        in_valid <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (timer_events_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (12) @(posedge clk);
        missing = timer_events_due.size();
        if (missing != 0)
            $display("%0d expected words never arrived", missing);
        if (fault_count == 0 && missing == 0)
            $display("** multi_channel_event_timer_unit: PASSED **");
        else
            $display("** multi_channel_event_timer_unit: FAILED **");
        $finish;
    end

endmodule
